### rtl/gltm_pkg.sv
// shared types, constants and register codes for the load telemetry monitor
package gltm_pkg;

   // request commands
   localparam logic [1:0] CMD_SLICE  = 2'd0;
   localparam logic [1:0] CMD_SLOT   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_UPDATE = 2'd3;

   // configuration register indexes
   localparam int          CSR_IDX_W   = 3;
   localparam int          CSR_DATA_W  = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CTHR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TTHR   = 3'd4;

   // reset values of the registers
   localparam logic [15:0] PERIOD_RST = 16'd250;
   localparam logic [3:0]  LIMIT_RST  = 4'd10;
   localparam logic [9:0]  CTHR_RST   = 10'd94;
   localparam logic [9:0]  TTHR_RST   = 10'd60;

   localparam logic [9:0]  NO_FRAG_RATIO = 10'd10;
   localparam logic [23:0] CNT_MAX       = 24'hFFFFFF;

   localparam int RING_SLOTS = 4;
   localparam int RING_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

   // shared divider geometry
   localparam int DIV_W     = 48;
   localparam int DIVISOR_W = 33;
   localparam int QUO_W     = 24;
   localparam int DCNT_W    = 5;
   localparam logic [DCNT_W-1:0] PCT_BITS = 5'd7;
   localparam logic [DCNT_W-1:0] CLK_BITS = 5'd24;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        flag;
      logic [31:0] slice_ns;
      logic [23:0] comp_time;
      logic [23:0] vert_time;
      logic [23:0] frag_time;
      logic [23:0] compute_jobs;
      logic [23:0] vertex_jobs;
      logic [23:0] fragment_jobs;
      logic [23:0] cur_clock;
      logic [31:0] now_ms;
      logic [63:0] out_counter;
   } req_type;

   typedef struct packed {
      logic        published;
      logic [23:0] avg_clock;
      logic [6:0]  avg_util;
      logic [3:0]  hcm_level;
      logic [63:0] out_delta;
      logic [1:0]  ring_index;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [DCNT_W-1:0] nbits;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### rtl/gltm_div.sv
// shared restoring divider, one quotient bit per cycle
module gltm_div (
   input  logic                            clock,
   input  logic                            reset,
   input  gltm_pkg::div_ctl_type           ctl,
   input  logic [gltm_pkg::DIV_W-1:0]      dividend,
   input  logic [gltm_pkg::DIVISOR_W-1:0]  divisor,
   output gltm_pkg::div_stat_type          stat,
   output logic [gltm_pkg::QUO_W-1:0]      quotient
);

   logic [gltm_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [gltm_pkg::DIV_W-1:0]  dsh_ff, dsh_in;
   logic [gltm_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [gltm_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         // align divisor with the top quotient bit
         rem_in  = dividend;
         dsh_in  = gltm_pkg::DIV_W'(divisor) << (ctl.nbits - 1'b1);
         quo_in  = '0;
         cnt_in  = ctl.nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[gltm_pkg::QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[gltm_pkg::QUO_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == gltm_pkg::DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

### rtl/gpu_load_telemetry_monitor.sv
// gpu load telemetry monitor: sequencer, accumulators and result register
// slice, slot, clear and source-off update requests: response valid the cycle after accept
// update without publish: CNT, TIME, UTIL, ACC, PUB, OUT; zero total time skips UTIL
// update with publish: adds the 24- and 7-bit quotient divisions for the two averages
// one request at a time; all divisions share the bit-serial divider
// reset (synchronous, active high) clears all accumulators and loads register defaults
module gpu_load_telemetry_monitor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  gltm_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gltm_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [gltm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gltm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CNT  = 4'd1;
   localparam logic [3:0] ST_TIME = 4'd2;
   localparam logic [3:0] ST_UTIL = 4'd3;
   localparam logic [3:0] ST_ACC  = 4'd4;
   localparam logic [3:0] ST_PUB  = 4'd5;
   localparam logic [3:0] ST_CLK  = 4'd6;
   localparam logic [3:0] ST_AVGU = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   logic [3:0]                  state_ff, state_in;
   gltm_pkg::req_type           req_ff, req_in;
   logic                        src_ff, src_in;
   logic [15:0]                 period_ff, period_in;
   logic [3:0]                  limit_ff, limit_in;
   logic [9:0]                  cthr_ff, cthr_in;
   logic [9:0]                  tthr_ff, tthr_in;
   logic [31:0]                 busy_t_ff, busy_t_in;
   logic [31:0]                 idle_t_ff, idle_t_in;
   logic                        slot_ff, slot_in;
   logic [3:0]                  hcm_ff, hcm_in;
   logic [47:0]                 clk_sum_ff, clk_sum_in;
   logic [31:0]                 util_sum_ff, util_sum_in;
   logic [23:0]                 smp_cnt_ff, smp_cnt_in;
   logic [31:0]                 last_pub_ff, last_pub_in;
   logic [63:0]                 last_oc_ff, last_oc_in;
   logic [gltm_pkg::RING_W-1:0] ring_ff, ring_in;
   logic                        cnt_ok_ff, cnt_ok_in;
   logic [6:0]                  util_ff, util_in;
   logic [23:0]                 avg_clk_ff, avg_clk_in;
   logic                        pub_ff, pub_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   gltm_pkg::rsp_type           rsp_ff, rsp_in;

   gltm_pkg::div_ctl_type            div_ctl;
   gltm_pkg::div_stat_type           div_stat;
   logic [gltm_pkg::DIV_W-1:0]       div_dividend;
   logic [gltm_pkg::DIVISOR_W-1:0]   div_divisor;
   logic [gltm_pkg::QUO_W-1:0]       div_quotient;

   logic                        req_take;
   logic [24:0]                 job_sum;
   logic [31:0]                 job_lhs;
   logic [34:0]                 job_rhs;
   logic [24:0]                 time_sum;
   logic [31:0]                 time_lhs;
   logic [34:0]                 time_rhs;
   logic [32:0]                 total_t;
   logic [31:0]                 elapsed;
   logic [gltm_pkg::RING_W-1:0] ring_next;

   gltm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;

   // ratio tests done as cross products: floor(n/d) > t iff n >= (t+1)*d
   assign job_sum  = 25'(req_ff.compute_jobs) + 25'(req_ff.vertex_jobs);
   assign job_lhs  = 32'(job_sum) * 32'd100;
   assign job_rhs  = 35'(11'(cthr_ff) + 11'd1) * 35'(req_ff.fragment_jobs);
   assign time_sum = 25'(req_ff.vert_time) + 25'(req_ff.comp_time);
   assign time_lhs = 32'(time_sum) * 32'd100;
   assign time_rhs = 35'(11'(tthr_ff) + 11'd1) * 35'(req_ff.frag_time);
   assign total_t  = 33'(busy_t_ff) + 33'(idle_t_ff);
   assign elapsed  = req_ff.now_ms - last_pub_ff;
   assign ring_next = (32'(ring_ff) == gltm_pkg::RING_SLOTS - 1) ? '0 : ring_ff + 1'b1;

   // divider operand selection follows the sequencer
   always_comb begin
      case (state_ff)
         ST_TIME: begin
            div_dividend = gltm_pkg::DIV_W'(40'(busy_t_ff) * 40'd100);
            div_divisor  = total_t;
         end
         ST_PUB: begin
            div_dividend = clk_sum_ff;
            div_divisor  = gltm_pkg::DIVISOR_W'(smp_cnt_ff);
         end
         default: begin
            div_dividend = gltm_pkg::DIV_W'(util_sum_ff);
            div_divisor  = gltm_pkg::DIVISOR_W'(smp_cnt_ff);
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      src_in       = src_ff;
      period_in    = period_ff;
      limit_in     = limit_ff;
      cthr_in      = cthr_ff;
      tthr_in      = tthr_ff;
      busy_t_in    = busy_t_ff;
      idle_t_in    = idle_t_ff;
      slot_in      = slot_ff;
      hcm_in       = hcm_ff;
      clk_sum_in   = clk_sum_ff;
      util_sum_in  = util_sum_ff;
      smp_cnt_in   = smp_cnt_ff;
      last_pub_in  = last_pub_ff;
      last_oc_in   = last_oc_ff;
      ring_in      = ring_ff;
      cnt_ok_in    = cnt_ok_ff;
      util_in      = util_ff;
      avg_clk_in   = avg_clk_ff;
      pub_in       = pub_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      div_ctl      = '0;

      if (csr_wr_en) begin
         case (csr_index)
            gltm_pkg::CSR_SRC:    src_in    = csr_wdata[0];
            gltm_pkg::CSR_PERIOD: period_in = csr_wdata;
            gltm_pkg::CSR_LIMIT:  limit_in  = csr_wdata[3:0];
            gltm_pkg::CSR_CTHR:   cthr_in   = csr_wdata[9:0];
            gltm_pkg::CSR_TTHR:   tthr_in   = csr_wdata[9:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in = req_data;
               case (req_data.cmd)
                  gltm_pkg::CMD_SLICE: begin
                     if (req_data.flag && slot_ff) begin
                        busy_t_in = busy_t_ff + req_data.slice_ns;
                     end else begin
                        idle_t_in = idle_t_ff + req_data.slice_ns;
                     end
                  end
                  gltm_pkg::CMD_SLOT: slot_in = req_data.flag;
                  gltm_pkg::CMD_CLEAR: begin
                     busy_t_in = '0;
                     idle_t_in = '0;
                  end
                  default: ;
               endcase
               if (req_data.cmd == gltm_pkg::CMD_UPDATE && src_ff) begin
                  state_in = ST_CNT;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end
            end
         end
         ST_CNT: begin
            if (job_sum == '0) begin
               cnt_ok_in = 1'b0;
            end else if (req_ff.fragment_jobs == '0) begin
               cnt_ok_in = gltm_pkg::NO_FRAG_RATIO > cthr_ff;
            end else begin
               cnt_ok_in = 35'(job_lhs) >= job_rhs;
            end
            state_in = ST_TIME;
         end
         ST_TIME: begin
            if (req_ff.frag_time != '0) begin
               if (cnt_ok_ff && (35'(time_lhs) >= time_rhs)) begin
                  if (hcm_ff < limit_ff) begin
                     hcm_in = hcm_ff + 1'b1;
                  end
               end else if (hcm_ff != '0) begin
                  hcm_in = hcm_ff - 1'b1;
               end
            end
            if (total_t == '0) begin
               util_in  = '0;
               state_in = ST_ACC;
            end else begin
               div_ctl.start = 1'b1;
               div_ctl.nbits = gltm_pkg::PCT_BITS;
               state_in      = ST_UTIL;
            end
         end
         ST_UTIL: begin
            if (div_stat.done) begin
               util_in  = div_quotient[6:0];
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            // a full sample counter freezes the sums until the next publish
            if (smp_cnt_ff != gltm_pkg::CNT_MAX) begin
               clk_sum_in  = clk_sum_ff + 48'(req_ff.cur_clock);
               util_sum_in = util_sum_ff + 32'(util_ff);
               smp_cnt_in  = smp_cnt_ff + 1'b1;
            end
            state_in = ST_PUB;
         end
         ST_PUB: begin
            pub_in = (elapsed >= 32'(period_ff)) && (smp_cnt_ff != '0);
            if ((elapsed >= 32'(period_ff)) && (smp_cnt_ff != '0)) begin
               div_ctl.start = 1'b1;
               div_ctl.nbits = gltm_pkg::CLK_BITS;
               state_in      = ST_CLK;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_CLK: begin
            if (div_stat.done) begin
               avg_clk_in    = div_quotient;
               div_ctl.start = 1'b1;
               div_ctl.nbits = gltm_pkg::PCT_BITS;
               state_in      = ST_AVGU;
            end
         end
         ST_AVGU: begin
            if (div_stat.done) begin
               util_in  = div_quotient[6:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_in           = '0;
               rsp_in.hcm_level = hcm_ff;
               if (pub_ff) begin
                  rsp_in.published  = 1'b1;
                  rsp_in.avg_clock  = avg_clk_ff;
                  rsp_in.avg_util   = util_ff;
                  rsp_in.out_delta  = req_ff.out_counter - last_oc_ff;
                  rsp_in.ring_index = 2'(ring_next);
                  clk_sum_in        = '0;
                  util_sum_in       = '0;
                  smp_cnt_in        = '0;
                  ring_in           = ring_next;
                  last_oc_in        = req_ff.out_counter;
                  last_pub_in       = req_ff.now_ms;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_ff       <= 1'b0;
         period_ff    <= gltm_pkg::PERIOD_RST;
         limit_ff     <= gltm_pkg::LIMIT_RST;
         cthr_ff      <= gltm_pkg::CTHR_RST;
         tthr_ff      <= gltm_pkg::TTHR_RST;
         busy_t_ff    <= '0;
         idle_t_ff    <= '0;
         slot_ff      <= 1'b0;
         hcm_ff       <= '0;
         clk_sum_ff   <= '0;
         util_sum_ff  <= '0;
         smp_cnt_ff   <= '0;
         last_pub_ff  <= '0;
         last_oc_ff   <= '0;
         ring_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         period_ff    <= period_in;
         limit_ff     <= limit_in;
         cthr_ff      <= cthr_in;
         tthr_ff      <= tthr_in;
         busy_t_ff    <= busy_t_in;
         idle_t_ff    <= idle_t_in;
         slot_ff      <= slot_in;
         hcm_ff       <= hcm_in;
         clk_sum_ff   <= clk_sum_in;
         util_sum_ff  <= util_sum_in;
         smp_cnt_ff   <= smp_cnt_in;
         last_pub_ff  <= last_pub_in;
         last_oc_ff   <= last_oc_in;
         ring_ff      <= ring_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      cnt_ok_ff  <= cnt_ok_in;
      util_ff    <= util_in;
      avg_clk_ff <= avg_clk_in;
      pub_ff     <= pub_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("request taken while sequencer busy");

   a_util_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.avg_util <= 7'd100)
      else $error("average utilization above 100");

   a_quiet_no_pub: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.published) |->
         (rsp_ff.avg_clock == '0 && rsp_ff.out_delta == '0 && rsp_ff.ring_index == '0))
      else $error("non-publishing response carries data");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_UTIL || state_ff == ST_CLK || state_ff == ST_AVGU))
      else $error("divider finished outside a wait state");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_stat.busy)
      else $error("divider running while sequencer idle");
`endif

endmodule

### verif/tb_gpu_load_telemetry_monitor.sv
// self-checking testbench for the gpu load telemetry monitor
module tb_gpu_load_telemetry_monitor;

   localparam int          PERCENT         = 100;
   localparam int          PHASES          = 8;
   localparam int          ITEMS_PER_PHASE = 207;
   localparam int          SETTLE_CYCLES   = 60;
   localparam longint      RUN_LIMIT       = 4000000;
   localparam logic [23:0] F24             = '1;
   localparam logic [63:0] F64             = '1;
   localparam logic [gltm_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd5;
   localparam logic [gltm_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   logic                            clock;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   gltm_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   gltm_pkg::rsp_type               rsp_data;
   logic                            csr_wr_en = 1'b0;
   logic [gltm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [gltm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   gpu_load_telemetry_monitor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // register copies
   logic        src_on    = 1'b0;
   logic [15:0] period_ms = gltm_pkg::PERIOD_RST;
   logic [3:0]  heavy_cap = gltm_pkg::LIMIT_RST;
   logic [9:0]  count_thr = gltm_pkg::CTHR_RST;
   logic [9:0]  time_thr  = gltm_pkg::TTHR_RST;

   // block state copies
   logic [31:0] busy_ns     = '0;
   logic [31:0] idle_ns     = '0;
   logic        slot_on     = 1'b0;
   logic [3:0]  heavy_level = '0;
   logic [47:0] clk_acc     = '0;
   logic [31:0] util_acc    = '0;
   logic [23:0] sample_n    = '0;
   logic [31:0] publish_ms  = '0;
   logic [63:0] odo_mark    = '0;
   int unsigned ring_slot   = 0;

   gltm_pkg::rsp_type telemetry_reports[$];
   int unsigned       report_faults = 0;

   // a table row may carry its own fixed report
   logic              table_fixed = 1'b0;
   gltm_pkg::rsp_type table_value = '0;

   // stimulus time base for well-formed update sequences
   logic [31:0] ms_now = '0;
   logic [63:0] odo    = '0;
   int unsigned burst_left = 0;
   int unsigned rx_hold    = 0;

   task automatic predict_telemetry(input gltm_pkg::req_type r, output gltm_pkg::rsp_type o);
      logic [63:0] total, util, jobs, cratio, tratio;
      logic [31:0] elapsed;
      o = '0;
      case (r.cmd)
         gltm_pkg::CMD_SLICE: begin
            if (r.flag && slot_on) busy_ns += r.slice_ns;
            else idle_ns += r.slice_ns;
         end
         gltm_pkg::CMD_SLOT: slot_on = r.flag;
         gltm_pkg::CMD_CLEAR: begin
            busy_ns = '0;
            idle_ns = '0;
         end
         gltm_pkg::CMD_UPDATE: begin
            if (src_on) begin
               total = 64'(busy_ns) + 64'(idle_ns);
               util = (total == 0) ? 64'd0 : (64'(busy_ns) * PERCENT) / total;
               if (r.frag_time != 0) begin
                  jobs = 64'(r.compute_jobs) + 64'(r.vertex_jobs);
                  if (jobs == 0) cratio = '0;
                  else if (r.fragment_jobs == 0) cratio = 64'(gltm_pkg::NO_FRAG_RATIO);
                  else cratio = (jobs * PERCENT) / 64'(r.fragment_jobs);
                  tratio = ((64'(r.vert_time) + 64'(r.comp_time)) * PERCENT)
                           / 64'(r.frag_time);
                  if (cratio > count_thr && tratio > time_thr) begin
                     if (heavy_level < heavy_cap) heavy_level++;
                  end else if (heavy_level > 0) begin
                     heavy_level--;
                  end
               end
               // saturated sample count stops accumulation until the next publish
               if (sample_n != gltm_pkg::CNT_MAX) begin
                  clk_acc  += 48'(r.cur_clock);
                  util_acc += util[31:0];
                  sample_n++;
               end
               o.hcm_level = heavy_level;
               elapsed = r.now_ms - publish_ms;
               if (elapsed >= period_ms && sample_n != 0) begin
                  o.published = 1'b1;
                  o.avg_clock = 24'(clk_acc / sample_n);
                  o.avg_util  = 7'(util_acc / sample_n);
                  clk_acc  = '0;
                  util_acc = '0;
                  sample_n = '0;
                  ring_slot = (ring_slot + 1) % gltm_pkg::RING_SLOTS;
                  o.out_delta  = r.out_counter - odo_mark;
                  o.ring_index = 2'(ring_slot);
                  odo_mark   = r.out_counter;
                  publish_ms = r.now_ms;
               end
            end
         end
         default: ;
      endcase
   endtask

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         report_faults++;
      end
   endfunction

   task automatic check_report(input gltm_pkg::rsp_type got);
      gltm_pkg::rsp_type want;
      if (telemetry_reports.size() == 0) begin
         $error("response with no request outstanding");
         report_faults++;
      end else begin
         want = telemetry_reports.pop_front();
         compare_field("published", 64'(want.published), 64'(got.published));
         compare_field("avg_clock", 64'(want.avg_clock), 64'(got.avg_clock));
         compare_field("avg_util", 64'(want.avg_util), 64'(got.avg_util));
         compare_field("hcm_level", 64'(want.hcm_level), 64'(got.hcm_level));
         compare_field("out_delta", want.out_delta, got.out_delta);
         compare_field("ring_index", 64'(want.ring_index), 64'(got.ring_index));
      end
   endtask

   always @(posedge clock) begin
      gltm_pkg::rsp_type predicted;
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_report(rsp_data);
         if (req_valid && req_ready) begin
            predict_telemetry(req_data, predicted);
            telemetry_reports.push_back(table_fixed ? table_value : predicted);
         end
         if (csr_wr_en) begin
            case (csr_index)
               gltm_pkg::CSR_SRC:    src_on    = csr_wdata[0];
               gltm_pkg::CSR_PERIOD: period_ms = csr_wdata[15:0];
               gltm_pkg::CSR_LIMIT:  heavy_cap = csr_wdata[3:0];
               gltm_pkg::CSR_CTHR:   count_thr = csr_wdata[9:0];
               gltm_pkg::CSR_TTHR:   time_thr  = csr_wdata[9:0];
               default: ;
            endcase
         end
      end
   end

   // receiver: short stalls, short ready runs and long stall-free stretches
   always @(negedge clock) begin
      if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_ready <= 1'b0;
               rx_hold   <= $urandom_range(1, 12);
            end
            1: begin
               rsp_ready <= 1'b1;
               rx_hold   <= $urandom_range(50, 400);
            end
            default: begin
               rsp_ready <= 1'b1;
               rx_hold   <= $urandom_range(0, 6);
            end
         endcase
      end
   end

   task automatic send_request(input gltm_pkg::req_type r, input logic fixed,
                               input gltm_pkg::rsp_type fixed_rsp);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_data    <= r;
      table_fixed = fixed;
      table_value = fixed_rsp;
      do @(posedge clock); while (!req_ready);
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 10)) @(negedge clock);
         burst_left = $urandom_range(0, 20);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      if (req_valid) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      while (telemetry_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [gltm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [gltm_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic gltm_pkg::req_type update_req(logic [23:0] ct, logic [23:0] vt,
                                                    logic [23:0] ft, logic [23:0] cj,
                                                    logic [23:0] vj, logic [23:0] fj,
                                                    logic [23:0] clk, logic [31:0] now,
                                                    logic [63:0] oc);
      gltm_pkg::req_type r;
      r = '0;
      r.cmd = gltm_pkg::CMD_UPDATE;
      r.comp_time     = ct;
      r.vert_time     = vt;
      r.frag_time     = ft;
      r.compute_jobs  = cj;
      r.vertex_jobs   = vj;
      r.fragment_jobs = fj;
      r.cur_clock     = clk;
      r.now_ms        = now;
      r.out_counter   = oc;
      return r;
   endfunction

   function automatic gltm_pkg::req_type slice_req(logic flag, logic [31:0] ns);
      gltm_pkg::req_type r;
      r = '0;
      r.cmd      = gltm_pkg::CMD_SLICE;
      r.flag     = flag;
      r.slice_ns = ns;
      return r;
   endfunction

   function automatic gltm_pkg::req_type cmd_req(logic [1:0] cmd, logic flag);
      gltm_pkg::req_type r;
      r = '0;
      r.cmd  = cmd;
      r.flag = flag;
      return r;
   endfunction

   function automatic gltm_pkg::req_type random_request();
      gltm_pkg::req_type r;
      int unsigned       pick;
      r.cmd           = 2'($urandom);
      r.flag          = 1'($urandom);
      r.slice_ns      = $urandom;
      r.comp_time     = 24'($urandom);
      r.vert_time     = 24'($urandom);
      r.frag_time     = 24'($urandom);
      r.compute_jobs  = 24'($urandom);
      r.vertex_jobs   = 24'($urandom);
      r.fragment_jobs = 24'($urandom);
      r.cur_clock     = 24'($urandom);
      r.now_ms        = $urandom;
      r.out_counter   = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 28) r.cmd = gltm_pkg::CMD_SLICE;
      else if (pick < 36) r.cmd = gltm_pkg::CMD_SLOT;
      else if (pick < 40) r.cmd = gltm_pkg::CMD_CLEAR;
      else r.cmd = gltm_pkg::CMD_UPDATE;
      if (r.cmd == gltm_pkg::CMD_SLICE && $urandom_range(0, 3) != 0)
         r.slice_ns = $urandom_range(0, 2000000);
      // most updates: ratios near the thresholds, time moving forward
      if (r.cmd == gltm_pkg::CMD_UPDATE && $urandom_range(0, 9) < 7) begin
         r.comp_time     = 24'($urandom_range(0, 300));
         r.vert_time     = 24'($urandom_range(0, 300));
         r.frag_time     = ($urandom_range(0, 5) == 0) ? 24'd0 : 24'($urandom_range(1, 300));
         r.compute_jobs  = ($urandom_range(0, 5) == 0) ? 24'd0 : 24'($urandom_range(1, 200));
         r.vertex_jobs   = ($urandom_range(0, 5) == 0) ? 24'd0 : 24'($urandom_range(1, 200));
         r.fragment_jobs = ($urandom_range(0, 5) == 0) ? 24'd0 : 24'($urandom_range(1, 300));
         ms_now += $urandom_range(0, 300);
         odo    += 64'($urandom_range(0, 100000));
         r.now_ms      = ms_now;
         r.out_counter = odo;
      end
      return r;
   endfunction

   typedef struct {
      logic                            is_csr;
      logic [gltm_pkg::CSR_IDX_W-1:0]  idx;
      logic [gltm_pkg::CSR_DATA_W-1:0] wdata;
      gltm_pkg::req_type               req;
      logic                            fixed;
      gltm_pkg::rsp_type               rsp;
   } plan_row_type;

   plan_row_type plan[$];

   function automatic void plan_csr(logic [gltm_pkg::CSR_IDX_W-1:0] idx,
                                    logic [gltm_pkg::CSR_DATA_W-1:0] val);
      plan_row_type row;
      row = '{1'b1, idx, val, '0, 1'b0, '0};
      plan.push_back(row);
   endfunction

   function automatic void plan_req(gltm_pkg::req_type r, logic fixed, gltm_pkg::rsp_type rsp);
      plan_row_type row;
      row = '{1'b0, '0, '0, r, fixed, rsp};
      plan.push_back(row);
   endfunction

   initial begin
      logic        ph_src;
      logic [15:0] ph_period;
      logic [3:0]  ph_limit;
      logic [9:0]  ph_cthr, ph_tthr;

      // source absent at reset: update reports zeros and touches nothing
      plan_req(update_req(F24, F24, F24, F24, F24, F24, F24, '1, F64), 1'b1, '0);
      plan_req(cmd_req(gltm_pkg::CMD_SLOT, 1'b1), 1'b1, '0);
      plan_req(slice_req(1'b1, 32'd300), 1'b1, '0);
      plan_req(slice_req(1'b0, 32'd100), 1'b1, '0);
      plan_csr(gltm_pkg::CSR_SRC, 16'hFFFF);
      plan_req(update_req('0, '0, '0, '0, '0, '0, F24, 32'd1000, F64), 1'b1,
               gltm_pkg::rsp_type'{1'b1, F24, 7'd75, 4'd0, F64, 2'd1});
      plan_req(update_req(F24, F24, 24'd1, F24, F24, 24'd1, 24'd10, 32'd1100, 64'd5), 1'b1,
               gltm_pkg::rsp_type'{1'b0, 24'd0, 7'd0, 4'd1, 64'd0, 2'd0});
      plan_req(update_req(F24, F24, 24'd1, F24, F24, 24'd1, F24, 32'd1150, 64'd6), 1'b0, '0);
      plan_req(update_req(F24, F24, 24'd1, F24, F24, 24'd1, '0, 32'd1200, 64'd7), 1'b0, '0);
      // counter above a lowered limit holds
      plan_csr(gltm_pkg::CSR_LIMIT, 16'hFFF1);
      plan_req(update_req(F24, F24, 24'd1, F24, F24, 24'd1, 24'd3, 32'd1249, 64'd8), 1'b0, '0);
      // no fragment jobs, then no compute or vertex jobs
      plan_req(update_req(24'd1, 24'd1, 24'd1, 24'd5, '0, '0, 24'd4, 32'd1250, 64'd9), 1'b0, '0);
      plan_req(update_req(24'd7, 24'd7, 24'd100, '0, '0, 24'd7, 24'd5, 32'd1260, 64'd10),
               1'b0, '0);
      // zero total time gives zero busy percent
      plan_req(cmd_req(gltm_pkg::CMD_CLEAR, 1'b0), 1'b1, '0);
      plan_req(update_req('0, '0, '0, '0, '0, '0, 24'd6, 32'd1270, 64'd11), 1'b0, '0);
      plan_req(slice_req(1'b1, '1), 1'b1, '0);
      plan_req(slice_req(1'b1, '1), 1'b1, '0);
      plan_req(cmd_req(gltm_pkg::CMD_SLOT, 1'b0), 1'b1, '0);
      plan_req(slice_req(1'b1, 32'd5), 1'b1, '0);
      plan_csr(CSR_UNUSED_LO, 16'h0000);
      plan_csr(CSR_UNUSED_HI, 16'hFFFF);
      plan_csr(gltm_pkg::CSR_PERIOD, 16'd1);
      plan_csr(gltm_pkg::CSR_LIMIT, 16'h000F);
      plan_csr(gltm_pkg::CSR_CTHR, 16'h0000);
      plan_csr(gltm_pkg::CSR_TTHR, 16'hFC00);
      // elapsed time wraps past zero
      plan_req(update_req('0, 24'd1, 24'd100, 24'd1, '0, 24'd100, F24, '0, '0), 1'b0, '0);
      plan_csr(gltm_pkg::CSR_PERIOD, 16'hFFFF);
      plan_csr(gltm_pkg::CSR_CTHR, 16'h03E8);
      plan_csr(gltm_pkg::CSR_TTHR, 16'hFFE8);
      plan_req(update_req(F24, F24, 24'd1, F24, F24, 24'd1, F24, 32'd65534, F64), 1'b0, '0);
      plan_req(update_req(F24, F24, 24'd1, F24, F24, 24'd1, F24, 32'd65535, 64'd1), 1'b0, '0);
      plan_csr(gltm_pkg::CSR_SRC, 16'hFFFE);
      plan_req(update_req(F24, F24, F24, F24, F24, F24, F24, '1, F64), 1'b1, '0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            drain();
            write_reg(plan[i].idx, plan[i].wdata);
         end else begin
            send_request(plan[i].req, plan[i].fixed, plan[i].rsp);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            1: begin
               ph_period = 16'd1;
               ph_limit  = 4'd15;
               ph_cthr   = 10'd0;
               ph_tthr   = 10'd0;
            end
            2: begin
               ph_period = 16'hFFFF;
               ph_limit  = 4'd1;
               ph_cthr   = 10'd1000;
               ph_tthr   = 10'd1000;
            end
            default: begin
               ph_period = 16'($urandom_range(1, 400));
               ph_limit  = 4'($urandom_range(1, 15));
               ph_cthr   = 10'($urandom_range(0, 200));
               ph_tthr   = 10'($urandom_range(0, 200));
            end
         endcase
         ph_src = (phase != 5);
         // unused upper data bits carry noise
         write_reg(gltm_pkg::CSR_SRC, (16'($urandom) & 16'hFFFE) | 16'(ph_src));
         write_reg(gltm_pkg::CSR_PERIOD, ph_period);
         write_reg(gltm_pkg::CSR_LIMIT, (16'($urandom) & 16'hFFF0) | 16'(ph_limit));
         write_reg(gltm_pkg::CSR_CTHR, (16'($urandom) & 16'hFC00) | 16'(ph_cthr));
         write_reg(gltm_pkg::CSR_TTHR, (16'($urandom) & 16'hFC00) | 16'(ph_tthr));
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 149) == 0) drain();
            send_request(random_request(), 1'b0, '0);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (report_faults == 0 && telemetry_reports.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### files.f
rtl/gltm_pkg.sv
rtl/gltm_div.sv
rtl/gpu_load_telemetry_monitor.sv
verif/tb_gpu_load_telemetry_monitor.sv
